FILE: src/wrhs_pkg.sv
// wrhs_pkg: shared constants, types and controller/datapath bundles
// for the water ripple height field block
// no dependencies
package wrhs_pkg;

  // grid geometry
  localparam int GRID_SIDE  = 128;
  localparam int CELLS      = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int CRD_W      = $clog2(GRID_SIDE);

  // field widths
  localparam int COORD_W    = 7;
  localparam int HEIGHT_W   = 16;
  localparam int SHIFT_W    = 4;
  localparam int FUNC_W     = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  // damping shift after reset
  localparam logic [SHIFT_W-1:0] DAMP_RESET = SHIFT_W'(6);

  // step streaming: window spans one row above to one row below the cell
  localparam int WIN_DEPTH  = 2 * GRID_SIDE + 1;
  localparam int STREAM_LEN = CELLS + 2 * GRID_SIDE;
  localparam int CNT_W      = $clog2(STREAM_LEN + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_STEP  = 2'd0,
    FUNC_SPAWN = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

  // order in which a spawn visits its five cells
  typedef enum logic [2:0] {
    TAP_CENTER,
    TAP_RIGHT,
    TAP_LEFT,
    TAP_DOWN,
    TAP_UP
  } tap_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP_RUN,
    ST_STEP_DRAIN,
    ST_SPAWN,
    ST_SPAWN_WB,
    ST_READ,
    ST_READ_WAIT,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_en;
    logic accept;
    logic step_issue;
    logic step_flip;
    logic spawn_issue;
    logic read_issue;
    logic read_capture;
    logic result_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic stream_last;
    logic pipe_busy;
    logic spawn_last;
    logic out_free;
  } status_t;

endpackage

FILE: src/wrhs_ram.sv
// wrhs_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module wrhs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/wrhs_ctrl.sv
// wrhs_ctrl: sequencer for clear, step, spawn and read operations
// depends on wrhs_pkg
module wrhs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  wrhs_pkg::func_t     in_func,
  output logic                in_tready,
  output wrhs_pkg::cmd_t      cmd_o,
  input  wrhs_pkg::status_t   status_i
);

  wrhs_pkg::state_t state_r;
  wrhs_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wrhs_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_tready = 1'b0;
    case (state_r)
      wrhs_pkg::ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (status_i.clear_last) begin
          state_nxt = wrhs_pkg::ST_IDLE;
        end
      end
      wrhs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_o.accept = 1'b1;
          case (in_func)
            wrhs_pkg::FUNC_STEP:  state_nxt = wrhs_pkg::ST_STEP_RUN;
            wrhs_pkg::FUNC_SPAWN: state_nxt = wrhs_pkg::ST_SPAWN;
            wrhs_pkg::FUNC_READ:  state_nxt = wrhs_pkg::ST_READ;
            default:              state_nxt = wrhs_pkg::ST_FINISH;
          endcase
        end
      end
      wrhs_pkg::ST_STEP_RUN: begin
        cmd_o.step_issue = 1'b1;
        if (status_i.stream_last) begin
          state_nxt = wrhs_pkg::ST_STEP_DRAIN;
        end
      end
      wrhs_pkg::ST_STEP_DRAIN: begin
        if (!status_i.pipe_busy) begin
          cmd_o.step_flip = 1'b1;
          state_nxt       = wrhs_pkg::ST_FINISH;
        end
      end
      wrhs_pkg::ST_SPAWN: begin
        cmd_o.spawn_issue = 1'b1;
        if (status_i.spawn_last) begin
          state_nxt = wrhs_pkg::ST_SPAWN_WB;
        end
      end
      wrhs_pkg::ST_SPAWN_WB: begin
        // last read-modify-write lands this cycle
        state_nxt = wrhs_pkg::ST_FINISH;
      end
      wrhs_pkg::ST_READ: begin
        cmd_o.read_issue = 1'b1;
        state_nxt        = wrhs_pkg::ST_READ_WAIT;
      end
      wrhs_pkg::ST_READ_WAIT: begin
        cmd_o.read_capture = 1'b1;
        state_nxt          = wrhs_pkg::ST_FINISH;
      end
      wrhs_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_nxt         = wrhs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wrhs_pkg::ST_IDLE;
      end
    endcase
  end

  // one item at a time: an accepted word always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.accept |=> !in_tready)
    else $error("input accepted twice in a row");

  // a result is never loaded while the previous state was the clear state
  a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.result_load |-> $past(state_r) != wrhs_pkg::ST_CLEAR)
    else $error("result produced right after clear");

endmodule

FILE: src/wrhs_dp.sv
// wrhs_dp: grid memories, step stencil pipeline, spawn update, read path
// and output register
// depends on wrhs_pkg and wrhs_ram
module wrhs_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wrhs_pkg::cmd_t                       cmd_i,
  output wrhs_pkg::status_t                    status_o,
  input  logic [wrhs_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [wrhs_pkg::FUNC_W-1:0]          in_tuser,
  input  logic                                 cfg_valid,
  input  logic [wrhs_pkg::SHIFT_W-1:0]         cfg_data,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [wrhs_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tuser
);

  localparam int AW = wrhs_pkg::ADDR_W;
  localparam int CW = wrhs_pkg::CRD_W;
  localparam int HW = wrhs_pkg::HEIGHT_W;
  localparam int S  = wrhs_pkg::GRID_SIDE;

  localparam logic [AW-1:0] LAST_CELL   = AW'(wrhs_pkg::CELLS - 1);
  localparam logic [AW-1:0] STREAM_BASE = AW'(wrhs_pkg::CELLS - S);
  localparam logic [CW-1:0] LAST_CRD    = CW'(S - 1);
  localparam logic [wrhs_pkg::CNT_W-1:0] EMIT_START  = wrhs_pkg::CNT_W'(2 * S);
  localparam logic [wrhs_pkg::CNT_W-1:0] STREAM_LAST = wrhs_pkg::CNT_W'(wrhs_pkg::STREAM_LEN - 1);
  localparam logic [wrhs_pkg::CNT_W-1:0] STREAM_END  = wrhs_pkg::CNT_W'(wrhs_pkg::STREAM_LEN);
  localparam logic [wrhs_pkg::COORD_W:0] SIDE_C = (wrhs_pkg::COORD_W + 1)'(S);

  function automatic logic [AW-1:0] cell_addr(logic [CW-1:0] y, logic [CW-1:0] x);
    return AW'(y) * AW'(S) + AW'(x);
  endfunction

  // ---- item and config registers
  wrhs_pkg::func_t              func_r;
  logic [CW-1:0]                x_r, y_r;
  logic signed [HW-1:0]         amp_r;
  logic [wrhs_pkg::SHIFT_W-1:0] damp_r;
  logic                         newest_b_r;

  logic [wrhs_pkg::COORD_W:0] x_ext, y_ext, x_red, y_red;

  assign x_ext = {1'b0, in_tdata[wrhs_pkg::COORD_W-1:0]};
  assign y_ext = {1'b0, in_tdata[2*wrhs_pkg::COORD_W-1:wrhs_pkg::COORD_W]};
  assign x_red = (x_ext >= SIDE_C) ? x_ext - SIDE_C : x_ext;
  assign y_red = (y_ext >= SIDE_C) ? y_ext - SIDE_C : y_ext;

  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      func_r <= wrhs_pkg::func_t'(in_tuser);
      x_r    <= x_red[CW-1:0];
      y_r    <= y_red[CW-1:0];
      amp_r  <= in_tdata[2*wrhs_pkg::COORD_W+HW-1:2*wrhs_pkg::COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r     <= wrhs_pkg::DAMP_RESET;
      newest_b_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        damp_r <= cfg_data;
      end
      if (cmd_i.step_flip) begin
        newest_b_r <= !newest_b_r;
      end
    end
  end

  // ---- memory ports, by role: newest grid and older grid
  logic [AW-1:0] new_raddr, new_waddr, old_raddr, old_waddr, clr_addr_r;
  logic [HW-1:0] new_rdata, old_rdata, new_wdata, old_wdata;
  logic          new_we, old_we;
  logic [AW-1:0] a_raddr, a_waddr, b_raddr, b_waddr;
  logic [HW-1:0] a_rdata, b_rdata, a_wdata, b_wdata;
  logic          a_we, b_we;

  assign new_rdata = newest_b_r ? b_rdata : a_rdata;
  assign old_rdata = newest_b_r ? a_rdata : b_rdata;

  assign a_raddr = newest_b_r ? old_raddr : new_raddr;
  assign b_raddr = newest_b_r ? new_raddr : old_raddr;
  assign a_we    = cmd_i.clear_en | (newest_b_r ? old_we : new_we);
  assign b_we    = cmd_i.clear_en | (newest_b_r ? new_we : old_we);
  assign a_waddr = cmd_i.clear_en ? clr_addr_r : (newest_b_r ? old_waddr : new_waddr);
  assign b_waddr = cmd_i.clear_en ? clr_addr_r : (newest_b_r ? new_waddr : old_waddr);
  assign a_wdata = cmd_i.clear_en ? '0 : (newest_b_r ? old_wdata : new_wdata);
  assign b_wdata = cmd_i.clear_en ? '0 : (newest_b_r ? new_wdata : old_wdata);

  wrhs_ram #(.WIDTH(HW), .DEPTH(wrhs_pkg::CELLS)) u_grid_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  wrhs_ram #(.WIDTH(HW), .DEPTH(wrhs_pkg::CELLS)) u_grid_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // ---- clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd_i.clear_en) begin
      clr_addr_r <= (clr_addr_r == LAST_CELL) ? '0 : clr_addr_r + 1'b1;
    end
  end

  // ---- step: stream newest grid through a window of 2*side+1 cells
  logic [AW-1:0]              rd_addr_r, j_addr_r, j2_r, j3_r;
  logic [wrhs_pkg::CNT_W-1:0] rd_cnt_r;
  logic                       p1_r, p1_emit_r, p2_r, p3_r;
  logic [HW-1:0]              win_r [wrhs_pkg::WIN_DEPTH];
  logic signed [HW-1:0]       v_r, v_nxt, damp_amt;
  logic signed [HW+1:0]       sum, half;
  logic [HW-1:0]              up_h, dn_h, lf_h, rt_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r <= STREAM_BASE;
      rd_cnt_r  <= '0;
      j_addr_r  <= '0;
      p1_r      <= 1'b0;
      p1_emit_r <= 1'b0;
      p2_r      <= 1'b0;
      p3_r      <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        rd_addr_r <= STREAM_BASE;
        rd_cnt_r  <= '0;
        j_addr_r  <= '0;
      end else if (cmd_i.step_issue) begin
        rd_addr_r <= (rd_addr_r == LAST_CELL) ? '0 : rd_addr_r + 1'b1;
        rd_cnt_r  <= rd_cnt_r + 1'b1;
      end
      if (p1_r && p1_emit_r) begin
        j_addr_r <= (j_addr_r == LAST_CELL) ? '0 : j_addr_r + 1'b1;
      end
      p1_r      <= cmd_i.step_issue;
      p1_emit_r <= cmd_i.step_issue && (rd_cnt_r >= EMIT_START);
      p2_r      <= p1_r && p1_emit_r;
      p3_r      <= p2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_r) begin
      win_r[0] <= new_rdata;
      for (int i = 1; i < wrhs_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
    j2_r <= j_addr_r;
    j3_r <= j2_r;
    v_r  <= v_nxt;
  end

  // window taps: newest entry is one row below the cell, oldest one row above
  assign dn_h = win_r[0];
  assign rt_h = win_r[S-1];
  assign lf_h = win_r[S+1];
  assign up_h = win_r[2*S];

  assign sum  = {{2{up_h[HW-1]}}, up_h} + {{2{dn_h[HW-1]}}, dn_h}
              + {{2{lf_h[HW-1]}}, lf_h} + {{2{rt_h[HW-1]}}, rt_h};
  assign half = sum >>> 1;
  assign v_nxt = half[HW-1:0] - old_rdata;

  assign damp_amt  = v_r >>> damp_r;
  assign old_raddr = j_addr_r;
  assign old_we    = p3_r;
  assign old_waddr = j3_r;
  assign old_wdata = v_r - damp_amt;

  // ---- spawn: five read-modify-writes on the newest grid
  wrhs_pkg::tap_t       sp_idx_r;
  logic                 sp_wr_en_r;
  logic [AW-1:0]        sp_wr_addr_r, tap_addr;
  logic signed [HW-1:0] sp_addend_r;
  logic [CW-1:0]        xp, xm, yp, ym;

  assign xp = (x_r == LAST_CRD) ? '0 : x_r + 1'b1;
  assign xm = (x_r == '0) ? LAST_CRD : x_r - 1'b1;
  assign yp = (y_r == LAST_CRD) ? '0 : y_r + 1'b1;
  assign ym = (y_r == '0) ? LAST_CRD : y_r - 1'b1;

  always_comb begin
    case (sp_idx_r)
      wrhs_pkg::TAP_CENTER: tap_addr = cell_addr(y_r, x_r);
      wrhs_pkg::TAP_RIGHT:  tap_addr = cell_addr(y_r, xp);
      wrhs_pkg::TAP_LEFT:   tap_addr = cell_addr(y_r, xm);
      wrhs_pkg::TAP_DOWN:   tap_addr = cell_addr(yp, x_r);
      wrhs_pkg::TAP_UP:     tap_addr = cell_addr(ym, x_r);
      default:              tap_addr = cell_addr(y_r, x_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_idx_r   <= wrhs_pkg::TAP_CENTER;
      sp_wr_en_r <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        sp_idx_r <= wrhs_pkg::TAP_CENTER;
      end else if (cmd_i.spawn_issue) begin
        sp_idx_r <= wrhs_pkg::tap_t'(3'(sp_idx_r + 3'd1));
      end
      sp_wr_en_r <= cmd_i.spawn_issue;
    end
  end

  always_ff @(posedge clk) begin
    sp_wr_addr_r <= tap_addr;
    sp_addend_r  <= (sp_idx_r == wrhs_pkg::TAP_CENTER) ? amp_r : (amp_r >>> 2);
  end

  assign new_we    = sp_wr_en_r;
  assign new_waddr = sp_wr_addr_r;
  assign new_wdata = new_rdata + sp_addend_r;

  always_comb begin
    new_raddr = cell_addr(y_r, x_r);
    if (cmd_i.step_issue) begin
      new_raddr = rd_addr_r;
    end else if (cmd_i.spawn_issue) begin
      new_raddr = tap_addr;
    end else if (cmd_i.read_issue) begin
      new_raddr = cell_addr(y_r, x_r);
    end
  end

  // ---- read capture and output register
  logic [HW-1:0] rd_hold_r;
  logic          out_valid_r;
  logic [HW-1:0] out_data_r;
  logic          out_user_r;

  always_ff @(posedge clk) begin
    if (cmd_i.read_capture) begin
      rd_hold_r <= new_rdata;
    end
    if (cmd_i.result_load) begin
      out_data_r <= (func_r == wrhs_pkg::FUNC_READ) ? rd_hold_r : '0;
      out_user_r <= (func_r == wrhs_pkg::FUNC_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign status_o.clear_last  = (clr_addr_r == LAST_CELL);
  assign status_o.stream_last = (rd_cnt_r == STREAM_LAST);
  assign status_o.pipe_busy   = p1_r | p2_r | p3_r;
  assign status_o.spawn_last  = (sp_idx_r == wrhs_pkg::TAP_UP);
  assign status_o.out_free    = !out_valid_r || out_tready;

  // never overwrite a result that is still waiting
  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.result_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // spawn writes and step writes never overlap
  a_no_mixed_writes: assert property (@(posedge clk) disable iff (!rst_n)
    sp_wr_en_r |-> !(p1_r || p2_r || p3_r))
    else $error("spawn write during step pipeline");

  // a frame swap only after the full stream and every cell written back
  a_flip_complete: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.step_flip |-> (rd_cnt_r == STREAM_END) && (j_addr_r == '0))
    else $error("grid swap before all cells updated");

endmodule

FILE: src/water_ripple_heightfield_step.sv
// water_ripple_heightfield_step: top level of the two-grid water ripple block
// depends on wrhs_pkg, wrhs_ctrl, wrhs_dp (which holds two wrhs_ram grids)
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in_     | slave     | in_tvalid/in_tready  | tdata: cell_x, cell_y, amplitude
//          |           |                      | tuser: func
//  out_    | master    | out_tvalid/out_tready| tdata: height_value
//          |           |                      | tuser: is_read_result
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_data: damping_shift
//
// operations: a step word streams all rows of the newest grid plus two more
//   (the wrap rows), one cell per cycle through its single read port into a
//   window of 2*GRID_SIDE+1 heights
// a spawn word does five read-modify-writes back to back, a read word one read
//   of the newest grid, an unused func code goes straight to its result
// reset: after rst_n both grids are zeroed by a sweep over all CELLS cells,
//   in_tready stays low during it; cfg writes are taken at any time outside reset
// stalls: a finished word sits in the output register while the next input
//   word is accepted; a second result waits only if that register is still full
module water_ripple_heightfield_step (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [wrhs_pkg::IN_DATA_W-1:0]      in_tdata,  // cell_x[6:0], cell_y[13:7], amplitude[29:14]
  input  logic [wrhs_pkg::FUNC_W-1:0]         in_tuser,  // func[1:0]
  // result words
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wrhs_pkg::OUT_DATA_W-1:0]     out_tdata, // height_value[15:0]
  output logic                                out_tuser, // is_read_result[0]
  // damping shift register write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wrhs_pkg::SHIFT_W-1:0]        cfg_data
);

  wrhs_pkg::cmd_t    cmd;
  wrhs_pkg::status_t status;

  // register writes never stall outside reset
  assign cfg_ready = rst_n;

  // sequencer: picks the operation from func and walks it through
  wrhs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (wrhs_pkg::func_t'(in_tuser)),
    .in_tready (in_tready),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  // grids, stencil pipeline, spawn adder and output register
  wrhs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: tb/sv/tb_water_ripple_heightfield_step.sv
// tb_water_ripple_heightfield_step: self-checking bench for the two-grid ripple block
// keeps a shadow copy of both height grids, predicts each result word, checks the out_ stream
// depends on wrhs_pkg and water_ripple_heightfield_step
module tb_water_ripple_heightfield_step;

  // func code with no operation; the block answers it with an all-zero word
  localparam logic [wrhs_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  // cycles with no handshake anywhere before the run is abandoned
  localparam int STALL_LIMIT = 100000;
  localparam int RANDOM_WORDS = 80;

  typedef struct {
    logic [wrhs_pkg::HEIGHT_W-1:0] height;
    logic                          is_read;
  } cell_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [wrhs_pkg::IN_DATA_W-1:0]  in_tdata;   // cell_x[6:0], cell_y[13:7], amplitude[29:14]
  logic [wrhs_pkg::FUNC_W-1:0]     in_tuser;   // func[1:0]
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [wrhs_pkg::OUT_DATA_W-1:0] out_tdata;  // height_value[15:0]
  logic                            out_tuser;  // is_read_result[0]
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [wrhs_pkg::SHIFT_W-1:0]    cfg_data;

  // shadow state: two grids, which one is newest, damping shift
  logic signed [wrhs_pkg::HEIGHT_W-1:0] heights [2][wrhs_pkg::CELLS];
  int                                   newest_sel;
  logic [wrhs_pkg::SHIFT_W-1:0]         damp_shift;

  cell_result_t height_expect[$];
  cell_result_t exp_r;

  bit no_idle;
  int errors;
  int stall_cycles;
  int results_seen;
  int step_words, spawn_words, read_words, unused_words, shift_writes;
  logic [wrhs_pkg::COORD_W-1:0] last_x, last_y;

  water_ripple_heightfield_step u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // one frame: new = (sum of four linear neighbours)/2 - value two frames back,
  // then subtract the damping term; neighbours wrap over the whole grid
  task automatic ripple_step_frame();
    int old_sel;
    int sum;
    int nc;
    int ns;
    logic signed [wrhs_pkg::HEIGHT_W-1:0] hv;
    nc = wrhs_pkg::CELLS;
    ns = wrhs_pkg::GRID_SIDE;
    old_sel = 1 - newest_sel;
    for (int j = 0; j < nc; j++) begin
      sum = int'(heights[newest_sel][(j + nc - ns) % nc])
          + int'(heights[newest_sel][(j + nc - 1) % nc])
          + int'(heights[newest_sel][(j + 1) % nc])
          + int'(heights[newest_sel][(j + ns) % nc]);
      hv = wrhs_pkg::HEIGHT_W'((sum >>> 1) - int'(heights[old_sel][j]));
      hv = hv - (hv >>> damp_shift);
      heights[old_sel][j] = hv;
    end
    newest_sel = old_sel;
  endtask

  task automatic bump_cell(int cx, int cy, logic signed [wrhs_pkg::HEIGHT_W-1:0] amount);
    int idx;
    idx = (cy % wrhs_pkg::GRID_SIDE) * wrhs_pkg::GRID_SIDE + (cx % wrhs_pkg::GRID_SIDE);
    heights[newest_sel][idx] = heights[newest_sel][idx] + amount;
  endtask

  // centre gets the amplitude, the four neighbours a quarter; row and column wrap apart
  task automatic ripple_spawn(logic [wrhs_pkg::COORD_W-1:0] cx,
                              logic [wrhs_pkg::COORD_W-1:0] cy,
                              logic signed [wrhs_pkg::HEIGHT_W-1:0] amp);
    logic signed [wrhs_pkg::HEIGHT_W-1:0] quarter;
    quarter = amp >>> 2;
    bump_cell(cx, cy, amp);
    bump_cell(cx + 1, cy, quarter);
    bump_cell(cx + wrhs_pkg::GRID_SIDE - 1, cy, quarter);
    bump_cell(cx, cy + 1, quarter);
    bump_cell(cx, cy + wrhs_pkg::GRID_SIDE - 1, quarter);
  endtask

  // ---------------------------------------------------------------- drivers

  // one input word; the expected result is worked out at the accepting edge
  task automatic send_word(logic [wrhs_pkg::FUNC_W-1:0] fn,
                           logic [wrhs_pkg::COORD_W-1:0] cx,
                           logic [wrhs_pkg::COORD_W-1:0] cy,
                           logic signed [wrhs_pkg::HEIGHT_W-1:0] amp);
    cell_result_t r;
    if (!no_idle && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, amp, cy, cx};
    in_tuser  <= fn;
    do @(posedge clk); while (!in_tready);
    r.height  = '0;
    r.is_read = 1'b0;
    case (fn)
      wrhs_pkg::FUNC_STEP: begin
        ripple_step_frame();
        step_words++;
      end
      wrhs_pkg::FUNC_SPAWN: begin
        ripple_spawn(cx, cy, amp);
        spawn_words++;
      end
      wrhs_pkg::FUNC_READ: begin
        r.height  = heights[newest_sel][int'(cy) * wrhs_pkg::GRID_SIDE + int'(cx)];
        r.is_read = 1'b1;
        read_words++;
      end
      default: unused_words++;
    endcase
    height_expect.push_back(r);
  endtask

  // sender holds off until every pending result word has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (height_expect.size() != 0);
  endtask

  task automatic write_damping(logic [wrhs_pkg::SHIFT_W-1:0] shift);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= shift;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    damp_shift = shift;
    shift_writes++;
  endtask

  // receiver: ready low about one cycle in ten, always high in the no-idle stretch
  always @(posedge clk) begin
    if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 10);
    end
  end

  // result checker: every accepted word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (height_expect.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, actual height %0d flag %0b",
                 $time, $signed(out_tdata), out_tuser);
      end else begin
        exp_r = height_expect.pop_front();
        if (out_tdata !== exp_r.height) begin
          errors++;
          $display("%0t: height_value expected %0d actual %0d", $time,
                   $signed(exp_r.height), $signed(out_tdata));
        end
        if (out_tuser !== exp_r.is_read) begin
          errors++;
          $display("%0t: is_read_result expected %0b actual %0b", $time,
                   exp_r.is_read, out_tuser);
        end
      end
    end
  end

  // watchdog: a step and the clearing sweep both run without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // the newest grid reads back cleared after reset; unused func code gives an all-zero word
  task automatic test_cleared_grid();
    send_word(wrhs_pkg::FUNC_READ, 7'd0, 7'd0, 16'sd0);
    send_word(wrhs_pkg::FUNC_READ, 7'd127, 7'd127, -16'sd1);
    send_word(FUNC_UNUSED, 7'd127, 7'd127, -16'sd1);
  endtask

  // spawns at the corners with extreme amplitudes plus a -1 spawn mid-grid, neighbours read across the wrap
  task automatic test_spawn_extremes();
    send_word(wrhs_pkg::FUNC_SPAWN, 7'd0, 7'd0, 16'sh7fff);
    send_word(wrhs_pkg::FUNC_SPAWN, 7'd0, 7'd0, 16'sh7fff);   // centre overflows and wraps
    send_word(wrhs_pkg::FUNC_READ, 7'd0, 7'd0, 16'sd0);
    send_word(wrhs_pkg::FUNC_READ, 7'd127, 7'd0, 16'sd0);
    send_word(wrhs_pkg::FUNC_READ, 7'd1, 7'd0, 16'sd0);
    send_word(wrhs_pkg::FUNC_READ, 7'd0, 7'd127, 16'sd0);
    send_word(wrhs_pkg::FUNC_READ, 7'd0, 7'd1, 16'sd0);
    send_word(wrhs_pkg::FUNC_SPAWN, 7'd127, 7'd127, -16'sh8000);
    send_word(wrhs_pkg::FUNC_SPAWN, 7'd64, 7'd32, -16'sd1);   // quarter of -1 stays -1
    send_word(wrhs_pkg::FUNC_READ, 7'd127, 7'd127, 16'sd0);
    send_word(wrhs_pkg::FUNC_READ, 7'd65, 7'd32, 16'sd0);
  endtask

  // steps at the largest, smallest nonzero and zero damping shift
  task automatic test_step_damping();
    write_damping(4'd15);
    send_word(wrhs_pkg::FUNC_STEP, 7'd0, 7'd0, 16'sd0);
    send_word(wrhs_pkg::FUNC_READ, 7'd1, 7'd0, 16'sd0);
    send_word(wrhs_pkg::FUNC_READ, 7'd127, 7'd126, 16'sd0);   // wraps from row end into next row
    write_damping(4'd1);
    send_word(wrhs_pkg::FUNC_STEP, 7'd127, 7'd127, -16'sd1);
    send_word(wrhs_pkg::FUNC_READ, 7'd0, 7'd0, 16'sd0);
    send_word(wrhs_pkg::FUNC_READ, 7'd2, 7'd0, 16'sd0);
    // zero shift: damping equals the value, every cell goes to zero
    write_damping(4'd0);
    send_word(wrhs_pkg::FUNC_STEP, 7'd0, 7'd0, 16'sd0);
    send_word(wrhs_pkg::FUNC_READ, 7'd0, 7'd0, 16'sd0);
    send_word(wrhs_pkg::FUNC_READ, 7'd127, 7'd127, 16'sd0);
  endtask

  // mostly spawn, step and read-back around the last drop, some random reads and noise
  task automatic test_random_traffic();
    int r;
    int steps_left;
    logic [wrhs_pkg::COORD_W-1:0] cx, cy;
    steps_left = 12;
    last_x = 7'($urandom);
    last_y = 7'($urandom);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // new damping setting each quarter, with the block drained first
      if (n % 20 == 0) begin
        case (n / 20)
          0: write_damping(4'd15);
          1: write_damping(4'd1);
          2: write_damping(wrhs_pkg::SHIFT_W'($urandom_range(2, 14)));
          default: write_damping(wrhs_pkg::DAMP_RESET);
        endcase
      end
      no_idle = (n >= 40 && n < 70);
      r = $urandom_range(99);
      if (r < 10 && steps_left > 0) begin
        steps_left--;
        send_word(wrhs_pkg::FUNC_STEP, 7'($urandom), 7'($urandom), 16'($urandom));
      end else if (r < 45) begin
        if ($urandom_range(1)) begin
          cx = last_x + 7'($urandom_range(0, 6)) - 7'd3;
          cy = last_y + 7'($urandom_range(0, 6)) - 7'd3;
        end else begin
          cx = 7'($urandom);
          cy = 7'($urandom);
        end
        send_word(wrhs_pkg::FUNC_SPAWN, cx, cy, 16'($urandom));
        last_x = cx;
        last_y = cy;
      end else if (r < 94) begin
        if ($urandom_range(99) < 65) begin
          cx = last_x + 7'($urandom_range(0, 8)) - 7'd4;
          cy = last_y + 7'($urandom_range(0, 8)) - 7'd4;
        end else begin
          cx = 7'($urandom);
          cy = 7'($urandom);
        end
        send_word(wrhs_pkg::FUNC_READ, cx, cy, 16'($urandom));
      end else begin
        send_word(FUNC_UNUSED, 7'($urandom), 7'($urandom), 16'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------- run

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    for (int s = 0; s < 2; s++) begin
      for (int j = 0; j < wrhs_pkg::CELLS; j++) heights[s][j] = '0;
    end
    newest_sel = 0;
    damp_shift = wrhs_pkg::DAMP_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_cleared_grid();
    test_spawn_extremes();
    test_step_damping();
    test_random_traffic();

    wait_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d steps, %0d spawns, %0d reads, %0d unused-code words",
             step_words, spawn_words, read_words, unused_words);
    $display("checked %0d result words over %0d damping shift settings",
             results_seen, shift_writes);
    if (errors == 0 && height_expect.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
